/* src/stfls_pkg.sv */
// Shared constants and types for the stance foot local shift block.
`default_nettype none
package stfls_pkg;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam int unsigned COS_CELLS = 5;
  localparam int unsigned SIN_CELLS = 4;
  localparam int unsigned COS_DIV [COS_CELLS] = '{90, 56, 30, 12, 2};
  localparam int unsigned SIN_DIV [SIN_CELLS] = '{72, 42, 20, 6};
  localparam logic signed [31:0] POS_MAX = 32'sd8388607;
  localparam logic signed [31:0] POS_MIN = -32'sd8388608;
  typedef logic signed [31:0] wide_t;
endpackage
`default_nettype wire

/* src/stance_foot_local_shift_core.sv */
// Top level: stance foot tip shift in the leg frame under planar body motion.
`default_nettype none
// One leg query enters per cycle while the output is not stalled, and passes
// through the three sine/cosine pipelines, which run side by side, then three levels
// of rotators, each followed by one register stage for the add, the subtract
// or the saturation. The whole pipeline advances on one enable, so a stalled
// output holds every stage. leg_count is written through the cfg channel,
// which is always ready. Invalid legs give zero shifts with bad_leg_o set.
module stance_foot_local_shift_core #(
  parameter int ANGLE_BITS = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire signed [23:0] start_x_i,
  input  wire signed [23:0] start_y_i,
  input  wire        [15:0] start_heading_i,
  input  wire signed [23:0] end_x_i,
  input  wire signed [23:0] end_y_i,
  input  wire        [15:0] end_heading_i,
  input  wire signed [23:0] mount_x_i,
  input  wire signed [23:0] mount_y_i,
  input  wire        [15:0] mount_angle_i,
  input  wire signed [23:0] tip_x_i,
  input  wire signed [23:0] tip_y_i,
  input  wire        [3:0]  leg_number_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic signed [23:0] shift_x_o,
  output logic signed [23:0] shift_y_o,
  output logic              bad_leg_o,
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire        [3:0]  cfg_data_i
);
  import stfls_pkg::*;
  localparam int DEPTH = 23;

  logic [3:0] leg_count_q;
  logic [DEPTH-1:0] vld_q;
  logic en;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leg_count_q <= 4'd6;
      vld_q       <= '0;
    end else begin
      if (cfg_valid_i) leg_count_q <= cfg_data_i;
      if (en) vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // angle pipelines
  logic [15:0] dh;
  wide_t c1, s1, cb, sb, cl, sl;
  assign dh = end_heading_i - start_heading_i;

  stfls_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_start (
    .clk_i(clk_i), .en_i(en), .ang_i(start_heading_i), .cs_o(c1), .sn_o(s1));
  stfls_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_delta (
    .clk_i(clk_i), .en_i(en), .ang_i(dh), .cs_o(cb), .sn_o(sb));
  stfls_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_mount (
    .clk_i(clk_i), .en_i(en), .ang_i(mount_angle_i), .cs_o(cl), .sn_o(sl));

  // payload delay lines, element j holds stage j+1
  wide_t dx_q [14], dy_q [14];
  wide_t mx_q [16], my_q [16];
  wide_t tx_q [22], ty_q [22];
  logic  bad_q [22];
  wide_t cld_q [3], sld_q [3], cbd_q [6], sbd_q [6];
  wide_t ux_q, uy_q, vx_q, vy_q;
  wide_t bx, by, rx, ry, lx, ly, nx, ny, zx, zy;
  logic signed [23:0] sx_q, sy_q;
  logic bad_o_q;
  logic bad_in;

  assign bad_in = (leg_number_i == 4'd0) || (leg_number_i > leg_count_q);

  function automatic logic signed [23:0] sat24(input wide_t v);
    logic signed [23:0] r;
    if (v > POS_MAX)      r = 24'sh7FFFFF;
    else if (v < POS_MIN) r = -24'sh800000;
    else                  r = v[23:0];
    return r;
  endfunction

  assign zx = tx_q[21];
  assign zy = ty_q[21];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q[0]  <= wide_t'(end_x_i) - wide_t'(start_x_i);
      dy_q[0]  <= wide_t'(end_y_i) - wide_t'(start_y_i);
      mx_q[0]  <= wide_t'(mount_x_i);
      my_q[0]  <= wide_t'(mount_y_i);
      tx_q[0]  <= wide_t'(tip_x_i);
      ty_q[0]  <= wide_t'(tip_y_i);
      bad_q[0] <= bad_in;
      for (int j = 1; j < 14; j++) begin
        dx_q[j] <= dx_q[j-1];
        dy_q[j] <= dy_q[j-1];
      end
      for (int j = 1; j < 16; j++) begin
        mx_q[j] <= mx_q[j-1];
        my_q[j] <= my_q[j-1];
      end
      for (int j = 1; j < 22; j++) begin
        tx_q[j]  <= tx_q[j-1];
        ty_q[j]  <= ty_q[j-1];
        bad_q[j] <= bad_q[j-1];
      end
      cld_q[0] <= cl;
      sld_q[0] <= sl;
      for (int j = 1; j < 3; j++) begin
        cld_q[j] <= cld_q[j-1];
        sld_q[j] <= sld_q[j-1];
      end
      cbd_q[0] <= cb;
      sbd_q[0] <= sb;
      for (int j = 1; j < 6; j++) begin
        cbd_q[j] <= cbd_q[j-1];
        sbd_q[j] <= sbd_q[j-1];
      end
      ux_q    <= bx + rx - mx_q[15];
      uy_q    <= by + ry - my_q[15];
      vx_q    <= tx_q[18] - lx;
      vy_q    <= ty_q[18] - ly;
      sx_q    <= bad_q[21] ? 24'sd0 : sat24(nx - zx);
      sy_q    <= bad_q[21] ? 24'sd0 : sat24(ny - zy);
      bad_o_q <= bad_q[21];
    end
  end

  // body step into the start heading frame, and mount swing by the heading change
  stfls_rot u_rot_step (
    .clk_i(clk_i), .en_i(en), .x_i(dx_q[13]), .y_i(dy_q[13]), .c_i(c1), .s_i(-s1),
    .x_o(bx), .y_o(by));
  stfls_rot u_rot_mount (
    .clk_i(clk_i), .en_i(en), .x_i(mx_q[13]), .y_i(my_q[13]), .c_i(cb), .s_i(sb),
    .x_o(rx), .y_o(ry));
  stfls_rot u_rot_leg (
    .clk_i(clk_i), .en_i(en), .x_i(ux_q), .y_i(uy_q), .c_i(cld_q[2]), .s_i(-sld_q[2]),
    .x_o(lx), .y_o(ly));
  stfls_rot u_rot_tip (
    .clk_i(clk_i), .en_i(en), .x_i(vx_q), .y_i(vy_q), .c_i(cbd_q[5]), .s_i(-sbd_q[5]),
    .x_o(nx), .y_o(ny));

  assign shift_x_o = sx_q;
  assign shift_y_o = sy_q;
  assign bad_leg_o = bad_o_q;

`ifndef SYNTH
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_leg_o |-> shift_x_o == 24'sd0 && shift_y_o == 24'sd0)
    else $error("bad leg with nonzero shift");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted transaction lost at entry");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline moved while stalled");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> leg_count_q == $past(cfg_data_i))
    else $error("leg_count write missed");
`endif
endmodule
`default_nettype wire

/* src/stfls_cell.sv */
// One series cell: t_o = 1 - round(x2 * t) / DIV, two register stages.
`default_nettype none
module stfls_cell #(
  parameter int unsigned DIV = 2
) (
  input  wire        clk_i,
  input  wire        en_i,
  input  wire [30:0] x2_i,
  input  wire [30:0] t_i,
  output logic [30:0] x2_o,
  output logic [30:0] t_o
);
  import stfls_pkg::*;
  localparam int unsigned K = 31 + $clog2(DIV);
  localparam int unsigned PW = K + 31;
  localparam logic [32:0] MUL = 33'(((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV));

  logic [61:0] p_q;
  logic [30:0] x2a_q, x2b_q;
  logic [PW-1:0] prod_q;
  logic [61:0] pr;
  logic [30:0] u;

  assign pr = p_q + (62'd1 << 29);
  assign u  = pr[60:30];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= 62'(x2_i) * 62'(t_i);
      x2a_q  <= x2_i;
      // floor division by DIV through a reciprocal, exact for 31-bit operands
      prod_q <= PW'(u) * PW'(MUL);
      x2b_q  <= x2a_q;
    end
  end

  assign x2_o = x2b_q;
  assign t_o  = ONE_Q30 - prod_q[PW-1:K];
endmodule
`default_nettype wire

/* src/stfls_trig.sv */
// Pipelined cosine and sine of a binary angle, Q1.30.
`default_nettype none
module stfls_trig #(
  parameter int ANGLE_BITS = 16
) (
  input  wire        clk_i,
  input  wire        en_i,
  input  wire [15:0] ang_i,
  output stfls_pkg::wide_t cs_o,
  output stfls_pkg::wide_t sn_o
);
  import stfls_pkg::*;
  localparam int DROP = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
  localparam logic [15:0] ANG_MASK = 16'(16'hFFFF << DROP);

  logic [15:0] a, asum, rr, mag;
  logic [1:0]  q;
  logic        neg;

  assign a    = ang_i & ANG_MASK;
  assign asum = a + 16'h2000;
  assign q    = asum[15:14];
  assign rr   = a - {q, 14'd0};
  assign neg  = rr[15];
  assign mag  = neg ? (~rr + 16'd1) : rr;

  logic [47:0] prod1_q;
  logic [30:0] xa_q, x3_q, x2_q;
  logic [1:0]  qd_q   [13];
  logic        negd_q [13];
  logic [30:0] xd_q   [8];
  logic [30:0] s12_q, s13_q;
  wide_t       cs_q, sn_q;
  logic [47:0] xr;
  logic [61:0] xx, sx;

  assign xr = prod1_q + 48'd16384;
  assign xx = 62'(xa_q) * 62'(xa_q) + (62'd1 << 29);

  logic [30:0] cx2 [COS_CELLS+1];
  logic [30:0] ct  [COS_CELLS+1];
  logic [30:0] st  [SIN_CELLS+1];

  assign cx2[0] = x2_q;
  assign ct[0]  = ONE_Q30;
  assign st[0]  = ONE_Q30;

  for (genvar i = 0; i < COS_CELLS; i++) begin : g_cos
    stfls_cell #(.DIV(COS_DIV[i])) u_cell (
      .clk_i(clk_i), .en_i(en_i), .x2_i(cx2[i]), .t_i(ct[i]),
      .x2_o(cx2[i+1]), .t_o(ct[i+1])
    );
  end

  // sine cells run in lockstep with the cosine cells and share their x2
  for (genvar i = 0; i < SIN_CELLS; i++) begin : g_sin
    stfls_cell #(.DIV(SIN_DIV[i])) u_cell (
      .clk_i(clk_i), .en_i(en_i), .x2_i(cx2[i]), .t_i(st[i]),
      .x2_o(), .t_o(st[i+1])
    );
  end

  assign sx = 62'(xd_q[7]) * 62'(st[SIN_CELLS]) + (62'd1 << 29);

  wide_t c13, s13;
  assign c13 = wide_t'({1'b0, ct[COS_CELLS]});
  assign s13 = negd_q[12] ? -wide_t'({1'b0, s13_q}) : wide_t'({1'b0, s13_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q   <= 48'(mag) * 48'(PI_Q30);
      xa_q      <= xr[45:15];
      x3_q      <= xa_q;
      x2_q      <= xx[60:30];
      qd_q[0]   <= q;
      negd_q[0] <= neg;
      for (int j = 1; j < 13; j++) begin
        qd_q[j]   <= qd_q[j-1];
        negd_q[j] <= negd_q[j-1];
      end
      xd_q[0] <= x3_q;
      for (int j = 1; j < 8; j++) xd_q[j] <= xd_q[j-1];
      s12_q <= sx[60:30];
      s13_q <= s12_q;
      case (qd_q[12])
        2'd0: begin cs_q <= c13;  sn_q <= s13;  end
        2'd1: begin cs_q <= -s13; sn_q <= c13;  end
        2'd2: begin cs_q <= -c13; sn_q <= -s13; end
        default: begin cs_q <= s13; sn_q <= -c13; end
      endcase
    end
  end

  assign cs_o = cs_q;
  assign sn_o = sn_q;
endmodule
`default_nettype wire

/* src/stfls_rot.sv */
// Rotation of a vector by [[c,-s],[s,c]] with Q1.30 rounding.
`default_nettype none
module stfls_rot (
  input  wire              clk_i,
  input  wire              en_i,
  input  stfls_pkg::wide_t x_i,
  input  stfls_pkg::wide_t y_i,
  input  stfls_pkg::wide_t c_i,
  input  stfls_pkg::wide_t s_i,
  output stfls_pkg::wide_t x_o,
  output stfls_pkg::wide_t y_o
);
  import stfls_pkg::*;
  logic signed [63:0] cx_q, sy_q, sx_q, cy_q;
  logic signed [64:0] ax, ay;
  wide_t ox_q, oy_q;

  assign ax = 65'(cx_q) - 65'(sy_q) + (65'sd1 <<< 29);
  assign ay = 65'(sx_q) + 65'(cy_q) + (65'sd1 <<< 29);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q <= 64'(c_i) * 64'(x_i);
      sy_q <= 64'(s_i) * 64'(y_i);
      sx_q <= 64'(s_i) * 64'(x_i);
      cy_q <= 64'(c_i) * 64'(y_i);
      ox_q <= ax[61:30];
      oy_q <= ay[61:30];
    end
  end

  assign x_o = ox_q;
  assign y_o = oy_q;
endmodule
`default_nettype wire
